// ----- src/saturating_stopwatch_defines.svh -----
// assertion macros shared by the stopwatch modules
`ifndef SATURATING_STOPWATCH_DEFINES_SVH
`define SATURATING_STOPWATCH_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define SW_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SW_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sw_pkg.sv -----
`default_nettype none

package sw_pkg;

	// tick counter width and field widths
	localparam int TICK_BITS  = 32;
	localparam int TOTAL_W    = 29;
	localparam int HOURS_W    = 7;
	localparam int MINUTES_W  = 6;
	localparam int SECONDS_W  = 6;
	localparam int MILLIS_W   = 10;
	localparam int CENTIS_W   = 7;
	localparam int SUM_W      = ((TICK_BITS > TOTAL_W) ? TICK_BITS : TOTAL_W) + 1;

	// remainder widths after each split
	localparam int REMH_W = 22;
	localparam int REMM_W = 16;

	// stream widths
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int RES_W     = TOTAL_W + 1 + CENTIS_W + MILLIS_W + SECONDS_W + MINUTES_W
		+ HOURS_W;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	// limits
	localparam logic [TOTAL_W-1:0] LIMIT_MAX   = 29'd359999999;
	localparam logic [TOTAL_W-1:0] LIMIT_RESET = 29'd35999999;

	// divisors
	localparam logic [TOTAL_W-1:0] MS_PER_HOUR = 29'd3600000;
	localparam logic [REMH_W-1:0]  MS_PER_MIN  = 22'd60000;
	localparam logic [REMM_W-1:0]  MS_PER_SEC  = 16'd1000;

	// reciprocals, floor(2^shift / divisor); estimate is exact or one low
	localparam logic [7:0] HOUR_RECIP = 8'd149;
	localparam int         HOUR_SHIFT = 29;
	localparam logic [6:0] MIN_RECIP  = 7'd69;
	localparam int         MIN_SHIFT  = 22;
	localparam logic [6:0] SEC_RECIP  = 7'd65;
	localparam int         SEC_SHIFT  = 16;
	// exact divide by ten for values below 1029
	localparam logic [7:0] TEN_RECIP  = 8'd205;
	localparam int         TEN_SHIFT  = 11;

	localparam int HP_W = TOTAL_W + 8;
	localparam int PM_W = REMH_W + 7;
	localparam int PS_W = REMM_W + 7;
	localparam int PC_W = MILLIS_W + 8;

	// output queue
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_REFRESH = 2'd0,
		OP_START   = 2'd1,
		OP_STOP    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// state snapshot handed to the converter
	typedef struct packed {
		logic               running;
		logic [TOTAL_W-1:0] total;
	} snap_t;

	// result, last field in the lowest bits
	typedef struct packed {
		logic [TOTAL_W-1:0]   total_ms;
		logic                 running_flag;
		logic [CENTIS_W-1:0]  centis;
		logic [MILLIS_W-1:0]  millis;
		logic [SECONDS_W-1:0] seconds;
		logic [MINUTES_W-1:0] minutes;
		logic [HOURS_W-1:0]   hours;
	} res_t;

endpackage

`default_nettype wire

// ----- src/sw_conv.sv -----
`default_nettype none
`include "saturating_stopwatch_defines.svh"

module sw_conv import sw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  snap_t in_snap,
	output logic  out_valid,
	output res_t  out_res
);

	logic [9:0] v_q;

	snap_t snap_s1, snap_s2, snap_s3, snap_s4, snap_s5;
	snap_t snap_s6, snap_s7, snap_s8, snap_s9, snap_s10;

	logic [HP_W-1:0]      ph_s1;
	logic [HOURS_W-1:0]   qh_s2;
	logic [TOTAL_W-1:0]   qdh_s2;
	logic [HOURS_W-1:0]   hours_s3, hours_s4, hours_s5, hours_s6, hours_s7;
	logic [HOURS_W-1:0]   hours_s8, hours_s9, hours_s10;
	logic [REMH_W-1:0]    remh_s3, remh_s4, remh_s5;
	logic [PM_W-1:0]      pm_s4;
	logic [MINUTES_W-1:0] qm_s5;
	logic [REMH_W-1:0]    qdm_s5;
	logic [MINUTES_W-1:0] minutes_s6, minutes_s7, minutes_s8, minutes_s9, minutes_s10;
	logic [REMM_W-1:0]    remm_s6, remm_s7, remm_s8;
	logic [PS_W-1:0]      ps_s7;
	logic [SECONDS_W-1:0] qs_s8;
	logic [REMM_W-1:0]    qds_s8;
	logic [SECONDS_W-1:0] seconds_s9, seconds_s10;
	logic [MILLIS_W-1:0]  millis_s9, millis_s10;
	logic [PC_W-1:0]      pc_s10;

	logic [HOURS_W-1:0]   qh_d;
	logic [TOTAL_W-1:0]   dh_d;
	logic [MINUTES_W-1:0] qm_d;
	logic [REMH_W-1:0]    dm_d;
	logic [SECONDS_W-1:0] qs_d;
	logic [REMM_W-1:0]    ds_d;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[8:0], in_valid};
		end
	end

	// quotient estimates and remainders
	always_comb begin
		qh_d = ph_s1[HOUR_SHIFT +: HOURS_W];
		dh_d = snap_s2.total - qdh_s2;
		qm_d = pm_s4[MIN_SHIFT +: MINUTES_W];
		dm_d = remh_s5 - qdm_s5;
		qs_d = ps_s7[SEC_SHIFT +: SECONDS_W];
		ds_d = remm_s8 - qds_s8;
	end

	// split pipeline: each split is product, back-multiply, correct
	always_ff @(posedge clk) begin
		// hours
		snap_s1 <= in_snap;
		ph_s1   <= HP_W'(in_snap.total) * HP_W'(HOUR_RECIP);

		snap_s2 <= snap_s1;
		qh_s2   <= qh_d;
		qdh_s2  <= TOTAL_W'(qh_d) * MS_PER_HOUR;

		snap_s3 <= snap_s2;
		if (dh_d >= MS_PER_HOUR) begin
			hours_s3 <= qh_s2 + HOURS_W'(1);
			remh_s3  <= REMH_W'(dh_d - MS_PER_HOUR);
		end else begin
			hours_s3 <= qh_s2;
			remh_s3  <= REMH_W'(dh_d);
		end

		// minutes
		snap_s4  <= snap_s3;
		hours_s4 <= hours_s3;
		remh_s4  <= remh_s3;
		pm_s4    <= PM_W'(remh_s3) * PM_W'(MIN_RECIP);

		snap_s5  <= snap_s4;
		hours_s5 <= hours_s4;
		remh_s5  <= remh_s4;
		qm_s5    <= qm_d;
		qdm_s5   <= REMH_W'(qm_d) * MS_PER_MIN;

		snap_s6  <= snap_s5;
		hours_s6 <= hours_s5;
		if (dm_d >= MS_PER_MIN) begin
			minutes_s6 <= qm_s5 + MINUTES_W'(1);
			remm_s6    <= REMM_W'(dm_d - MS_PER_MIN);
		end else begin
			minutes_s6 <= qm_s5;
			remm_s6    <= REMM_W'(dm_d);
		end

		// seconds
		snap_s7    <= snap_s6;
		hours_s7   <= hours_s6;
		minutes_s7 <= minutes_s6;
		remm_s7    <= remm_s6;
		ps_s7      <= PS_W'(remm_s6) * PS_W'(SEC_RECIP);

		snap_s8    <= snap_s7;
		hours_s8   <= hours_s7;
		minutes_s8 <= minutes_s7;
		remm_s8    <= remm_s7;
		qs_s8      <= qs_d;
		qds_s8     <= REMM_W'(qs_d) * MS_PER_SEC;

		snap_s9    <= snap_s8;
		hours_s9   <= hours_s8;
		minutes_s9 <= minutes_s8;
		if (ds_d >= MS_PER_SEC) begin
			seconds_s9 <= qs_s8 + SECONDS_W'(1);
			millis_s9  <= MILLIS_W'(ds_d - MS_PER_SEC);
		end else begin
			seconds_s9 <= qs_s8;
			millis_s9  <= MILLIS_W'(ds_d);
		end

		// centiseconds
		snap_s10    <= snap_s9;
		hours_s10   <= hours_s9;
		minutes_s10 <= minutes_s9;
		seconds_s10 <= seconds_s9;
		millis_s10  <= millis_s9;
		pc_s10      <= PC_W'(millis_s9) * PC_W'(TEN_RECIP);
	end

	// result assembly
	always_comb begin
		out_valid            = v_q[9];
		out_res.hours        = hours_s10;
		out_res.minutes      = minutes_s10;
		out_res.seconds      = seconds_s10;
		out_res.millis       = millis_s10;
		out_res.centis       = pc_s10[TEN_SHIFT +: CENTIS_W];
		out_res.running_flag = snap_s10.running;
		out_res.total_ms     = snap_s10.total;
	end

	`SW_ASSERT_IMP(a_split_in_range, out_valid, out_res.minutes < 6'd60 && out_res.seconds < 6'd60 && out_res.millis < 10'd1000, "split field out of range")
	`SW_ASSERT_IMP(a_hours_bound, out_valid, out_res.hours <= 7'd99 && out_res.centis <= 7'd99, "hours or centis out of range")

endmodule

`default_nettype wire

// ----- src/saturating_stopwatch.sv -----
// saturating stopwatch
// requests arrive on the s_ channel: s_tuser carries the operation (refresh, start,
// stop, clear) and s_tdata the current free-running millisecond tick. every request
// gives exactly one result on the m_ channel with the elapsed count split into
// hours, minutes, seconds, milliseconds and centiseconds, the running flag and the
// raw count. the limit register is written through cfg_we / cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this. a result passes
// the snapshot register, the split pipeline and the output queue before m_tvalid
// rises. the state update is one add and compare, so a request is taken every cycle
// while s_tready is high. the split runs through a ten-stage reciprocal-multiply
// pipeline into a 16-entry output queue; s_tready drops once 16 requests are
// outstanding (accepted but not yet taken from the m_ side).
// when the receiver stalls the queue fills and s_tready falls, no result is lost;
// full rate is held whenever m_tready stays high.
// reset: limit 35999999 ms, count zero, stopped, base tick zero, queue empty.
`default_nettype none
`include "saturating_stopwatch_defines.svh"

module saturating_stopwatch import sw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TOTAL_W-1:0]   cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// now_tick [31:0]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation [1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hours [6:0], minutes [12:7], seconds [18:13], millis [28:19], centis [35:29],
	// running_flag [36], total_ms [65:37], zeros above
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic [TOTAL_W-1:0]   limit_q;
	logic [TOTAL_W-1:0]   elapsed_q;
	logic                 running_q;
	logic [TICK_BITS-1:0] base_q;

	logic                 s_acc;
	op_t                  op;
	logic [TICK_BITS-1:0] now_t;
	logic [TOTAL_W-1:0]   lim;
	logic [TICK_BITS-1:0] delta;
	logic [SUM_W-1:0]     sum;
	logic                 sat;

	logic [TOTAL_W-1:0]   elapsed_d;
	logic                 running_d;
	logic [TICK_BITS-1:0] base_d;

	logic  valid_s1;
	snap_t snap_s1;

	logic conv_valid;
	res_t conv_res;

	res_t                  fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fifo_cnt_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign s_acc = s_tvalid & s_tready;
	assign op    = op_t'(s_tuser);
	assign now_t = s_tdata[TICK_BITS-1:0];

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// next state per operation: accumulate and saturate, start, stop, clear
	always_comb begin
		lim   = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
		delta = (op == OP_START) ? '0 : now_t - base_q;
		sum   = SUM_W'(elapsed_q) + SUM_W'(delta);
		sat   = sum >= SUM_W'(lim);

		elapsed_d = elapsed_q;
		running_d = running_q;
		base_d    = base_q;
		unique case (op)
			OP_REFRESH: begin
				if (running_q) begin
					base_d = now_t;
					if (sat) begin
						elapsed_d = lim;
						running_d = 1'b0;
					end else begin
						elapsed_d = sum[TOTAL_W-1:0];
					end
				end
			end
			OP_START: begin
				base_d = now_t;
				if (sat) begin
					elapsed_d = lim;
					running_d = 1'b0;
				end else begin
					running_d = 1'b1;
				end
			end
			OP_STOP: begin
				running_d = 1'b0;
			end
			OP_CLEAR: begin
				running_d = 1'b0;
				elapsed_d = '0;
			end
		endcase
	end

	// stopwatch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			running_q <= 1'b0;
			base_q    <= '0;
		end else if (s_acc) begin
			elapsed_q <= elapsed_d;
			running_q <= running_d;
			base_q    <= base_d;
		end
	end

	// snapshot stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_acc;
		end
	end

	always_ff @(posedge clk) begin
		snap_s1.running <= running_d;
		snap_s1.total   <= elapsed_d;
	end

	// time split pipeline
	sw_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_snap   (snap_s1),
		.out_valid (conv_valid),
		.out_res   (conv_res)
	);

	// output queue storage
	always_ff @(posedge clk) begin
		if (conv_valid) begin
			fifo_q[wr_ptr_q] <= conv_res;
		end
	end

	assign pop = m_tvalid & m_tready;

	// queue pointers and outstanding request count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (conv_valid) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(conv_valid) - FIFO_CNT_W'(pop);
			cnt_q      <= cnt_q + FIFO_CNT_W'(s_acc) - FIFO_CNT_W'(pop);
		end
	end

	assign s_tready = cnt_q < FIFO_CNT_W'(FIFO_DEPTH);
	assign m_tvalid = fifo_cnt_q != '0;
	assign m_tdata  = M_TDATA_W'(fifo_q[rd_ptr_q]);

	`SW_ASSERT_IMP(a_credit_bound, 1'b1,
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "outstanding requests exceed queue depth")
	`SW_ASSERT_IMP(a_queue_within_credit, 1'b1,
		fifo_cnt_q <= cnt_q, "queue holds more results than requests")
	`SW_ASSERT_IMP(a_count_in_range, 1'b1,
		elapsed_q <= LIMIT_MAX, "elapsed count above maximum limit")
	`SW_ASSERT_NXT(a_clear_stops, s_acc && op == OP_CLEAR,
		!running_q && elapsed_q == '0, "clear did not stop and zero")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
	import sw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 50;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [TOTAL_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// stopwatch state as the predictor sees it
	logic [TOTAL_W-1:0]   sw_limit = LIMIT_RESET;
	logic [TOTAL_W-1:0]   sw_elapsed = '0;
	logic                 sw_running = 1'b0;
	logic [TICK_BITS-1:0] sw_base = '0;

	res_t pending_times[$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   rx_stall_left = 0;
	bit   tx_idle = 1'b1;
	bit   rx_idle = 1'b1;
	logic [TICK_BITS-1:0] free_tick = '0;

	saturating_stopwatch DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_times.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic compare_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// refresh: add ticks since the base while running, saturating at the limit
	function automatic void accumulate_ticks(logic [TICK_BITS-1:0] tick);
		logic [TICK_BITS-1:0] delta;
		logic [SUM_W-1:0]     sum;
		logic [TOTAL_W-1:0]   lim;
		if (!sw_running)
			return;
		lim = (sw_limit > LIMIT_MAX) ? LIMIT_MAX : sw_limit;
		delta = tick - sw_base;
		sum = SUM_W'(sw_elapsed) + SUM_W'(delta);
		sw_base = tick;
		if (sum >= SUM_W'(lim)) begin
			sum = SUM_W'(lim);
			sw_running = 1'b0;
		end
		sw_elapsed = sum[TOTAL_W-1:0];
	endfunction

	// apply one request and split the count into display fields
	function automatic res_t advance_stopwatch(op_t op, logic [TICK_BITS-1:0] tick);
		res_t        r;
		int unsigned t;
		case (op)
			OP_REFRESH: begin
				accumulate_ticks(tick);
			end
			OP_START: begin
				sw_running = 1'b1;
				sw_base = tick;
				accumulate_ticks(tick);
			end
			OP_STOP: begin
				sw_running = 1'b0;
			end
			default: begin
				sw_running = 1'b0;
				sw_elapsed = '0;
			end
		endcase
		t = 32'(sw_elapsed);
		r.hours = HOURS_W'(t / MS_PER_HOUR);
		t = t % MS_PER_HOUR;
		r.minutes = MINUTES_W'(t / MS_PER_MIN);
		t = t % MS_PER_MIN;
		r.seconds = SECONDS_W'(t / MS_PER_SEC);
		t = t % MS_PER_SEC;
		r.millis = MILLIS_W'(t);
		r.centis = CENTIS_W'(t / 10);
		r.running_flag = sw_running;
		r.total_ms = sw_elapsed;
		return r;
	endfunction

	// one request on the s_ side, with a random lead-in gap while tx_idle is set
	task automatic send_request(op_t op, logic [TICK_BITS-1:0] tick);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= tick;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_times.push_back(advance_stopwatch(op, tick));
	endtask

	// hold off until every outstanding result has been taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_times.size() != 0);
	endtask

	task automatic write_limit(logic [TOTAL_W-1:0] value);
		drain_results();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sw_limit = value;
		@(posedge clk);
	endtask

	// result side: check each result, then stall m_tready at random while rx_idle is set
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			if (pending_times.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding, total_ms %0d",
					got.total_ms));
			end else begin
				want = pending_times.pop_front();
				compare_field("hours", 32'(got.hours), 32'(want.hours));
				compare_field("minutes", 32'(got.minutes), 32'(want.minutes));
				compare_field("seconds", 32'(got.seconds), 32'(want.seconds));
				compare_field("millis", 32'(got.millis), 32'(want.millis));
				compare_field("centis", 32'(got.centis), 32'(want.centis));
				compare_field("running_flag", 32'(got.running_flag),
					32'(want.running_flag));
				compare_field("total_ms", 32'(got.total_ms), 32'(want.total_ms));
			end
			rx_stall_left = rx_idle ? $urandom_range(0, 6) : 0;
		end
		if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// every operation, stopped and running, tick wrap and a saturating jump
	task automatic test_operations();
		send_request(OP_REFRESH, 32'h0000_0000);
		send_request(OP_STOP, 32'h0000_0010);
		send_request(OP_CLEAR, 32'h0000_0020);
		send_request(OP_START, 32'hFFFF_FF00);
		send_request(OP_REFRESH, 32'h0000_0100);
		send_request(OP_REFRESH, 32'h0000_F0A5);
		send_request(OP_START, 32'h0010_0000);
		send_request(OP_REFRESH, 32'h0010_EF32);
		send_request(OP_STOP, 32'h0020_0000);
		send_request(OP_REFRESH, 32'h0030_0000);
		send_request(OP_START, 32'hFFFF_FFFF);
		send_request(OP_REFRESH, 32'h7FFF_FFFF);
		send_request(OP_CLEAR, 32'h8000_0000);
	endtask

	// limit of zero and one, above range, at maximum, lowered below the count
	task automatic test_limit_edges();
		write_limit('0);
		send_request(OP_START, 32'h0000_0064);
		write_limit(29'd1);
		send_request(OP_START, 32'h0000_0005);
		send_request(OP_REFRESH, 32'h0000_0006);
		write_limit('1);
		send_request(OP_START, 32'h0000_0000);
		send_request(OP_REFRESH, 32'hFFFF_FFFF);
		send_request(OP_START, 32'h1234_5678);
		write_limit(LIMIT_MAX);
		send_request(OP_CLEAR, 32'h0000_0000);
		send_request(OP_START, 32'h0000_0000);
		send_request(OP_REFRESH, 32'd359999998);
		send_request(OP_REFRESH, 32'd359999997);
		send_request(OP_CLEAR, 32'h0000_0000);
		send_request(OP_START, 32'h0000_0000);
		send_request(OP_REFRESH, 32'd90000);
		send_request(OP_STOP, 32'd95000);
		write_limit(29'd5000);
		send_request(OP_REFRESH, 32'd200000);
		send_request(OP_START, 32'd300000);
	endtask

	// sessions of mostly refreshes on a forward-running tick, with odd jumps
	task automatic test_random_traffic(logic [TOTAL_W-1:0] limit, int count,
			int unsigned step_max, bit hold_off);
		int          pick;
		op_t         op;
		logic [TICK_BITS-1:0] tick;
		write_limit(limit);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				tx_idle = $urandom_range(0, 2) != 0;
				rx_idle = $urandom_range(0, 2) != 0;
			end
			if (hold_off && i == count / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 60)
				op = OP_REFRESH;
			else if (pick < 75)
				op = OP_START;
			else if (pick < 87)
				op = OP_STOP;
			else
				op = OP_CLEAR;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				tick = $urandom();
			else if (pick < 10)
				tick = free_tick;
			else
				tick = free_tick + $urandom_range(0, step_max);
			free_tick = tick;
			send_request(op, tick);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operations();
		test_limit_edges();
		test_random_traffic(LIMIT_RESET, 330, 4000000, 1'b1);
		test_random_traffic(TOTAL_W'($urandom_range(1, 2000)), 330, 400, 1'b0);
		test_random_traffic(LIMIT_MAX, 330, 40000000, 1'b1);
		test_random_traffic(TOTAL_W'($urandom_range(LIMIT_MAX + 1, 29'h1FFF_FFFF)),
			330, 40000000, 1'b0);
		test_random_traffic(TOTAL_W'($urandom_range(1, LIMIT_MAX)), 330, 2000000,
			1'b0);
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
